// ===== sv/naa_pkg.sv =====
// Shared types and constants for the numeric aggregate accumulator.
// Used by naa_ctrl, naa_dp and the numeric_aggregate_accumulator top level.
// No dependencies.
`default_nettype none

package naa_pkg;

    localparam int HALF_W    = 64;
    localparam int VAL_W     = 2 * HALF_W;
    localparam int CNT_W     = 64;
    localparam int FN_W      = 3;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Function select codes; 5 to 7 are unused and give a zero result
    localparam logic [FN_W-1:0] FN_COUNT = 3'd0;
    localparam logic [FN_W-1:0] FN_SUM   = 3'd1;
    localparam logic [FN_W-1:0] FN_AVG   = 3'd2;
    localparam logic [FN_W-1:0] FN_MIN   = 3'd3;
    localparam logic [FN_W-1:0] FN_MAX   = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_ROW   = 2'd2,
        CMD_FINAL = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FINAL   = 2'd1,
        ST_ROW_ERR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        DP_NONE     = 3'd0,
        DP_CLEAR    = 3'd1,
        DP_VALUE    = 3'd2,
        DP_ROW      = 3'd3,
        DP_FINAL    = 3'd4,
        DP_DIV_LOAD = 3'd5,
        DP_DIV_STEP = 3'd6,
        DP_DIV_DONE = 3'd7
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic fn_avg;
        logic count_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/naa_ctrl.sv =====
// Controller for the numeric aggregate accumulator: decodes requests and
// sequences the bit-serial division for average. Depends on naa_pkg.
`default_nettype none

module naa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_command,
    input  wire naa_pkg::t_dp_stat i_stat,
    output naa_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import naa_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_cmd.op = DP_NONE;
        o_busy   = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (t_cmd'(i_command))
                        CMD_CLEAR: o_cmd.op = DP_CLEAR;
                        CMD_VALUE: o_cmd.op = DP_VALUE;
                        CMD_ROW:   o_cmd.op = DP_ROW;
                        CMD_FINAL: begin
                            // average over a nonzero count needs the divider
                            if (i_stat.fn_avg && !i_stat.count_zero) begin
                                o_cmd.op = DP_DIV_LOAD;
                                n_state  = S_DIV;
                            end else begin
                                o_cmd.op = DP_FINAL;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                    n_step  = '0;
                end
            end
            S_DONE: begin
                o_cmd.op = DP_DIV_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && t_cmd'(i_command) == CMD_FINAL
         && i_stat.fn_avg && !i_stat.count_zero) |=> (r_state == S_DIV && r_step == '0))
        else $error("average finalize did not start the divider");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_step == '0))
        else $error("step counter running outside division");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("done state held for more than one cycle");

endmodule

`default_nettype wire

// ===== sv/naa_dp.sv =====
// Datapath for the numeric aggregate accumulator: running sum, count,
// extremum, bit-serial divider and result register. Depends on naa_pkg.
`default_nettype none

module naa_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire naa_pkg::t_dp_cmd                    i_cmd,
    input  wire logic                                i_cfg_we,
    input  wire logic [naa_pkg::FN_W-1:0]            i_cfg_data,
    input  wire logic signed [naa_pkg::HALF_W-1:0]   i_value_high,
    input  wire logic [naa_pkg::HALF_W-1:0]          i_value_low,
    output naa_pkg::t_dp_stat                        o_stat,
    output logic                                     o_result_valid,
    output logic [naa_pkg::STATUS_W-1:0]             o_status,
    output logic signed [naa_pkg::HALF_W-1:0]        o_result_high,
    output logic [naa_pkg::HALF_W-1:0]               o_result_low,
    output logic                                     o_result_empty
);
    import naa_pkg::*;

    // control state, cleared by reset
    logic [FN_W-1:0]  r_fn, n_fn;
    logic [VAL_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_has_ext, n_has_ext;
    logic             r_valid, n_valid;

    // payload
    logic [VAL_W-1:0] r_ext, n_ext;
    logic [VAL_W-1:0] r_res, n_res;
    t_status          r_status, n_status;
    logic             r_empty, n_empty;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_quo, n_quo;
    logic             r_neg, n_neg;

    logic [VAL_W-1:0] w_value;
    logic             w_repl;
    logic [CNT_W:0]   w_shift;
    logic [CNT_W+1:0] w_diff;

    assign w_value = {i_value_high, i_value_low};
    assign w_shift = {r_rem, r_quo[VAL_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_count};

    always_comb begin
        if (!r_has_ext) begin
            w_repl = 1'b1;
        end else if (r_fn == FN_MIN) begin
            w_repl = $signed(w_value) < $signed(r_ext);
        end else begin
            w_repl = $signed(r_ext) < $signed(w_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn      <= FN_COUNT;
            r_sum     <= '0;
            r_count   <= '0;
            r_has_ext <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_fn      <= n_fn;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_has_ext <= n_has_ext;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext    <= n_ext;
        r_res    <= n_res;
        r_status <= n_status;
        r_empty  <= n_empty;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_neg    <= n_neg;
    end

    always_comb begin
        n_fn      = i_cfg_we ? i_cfg_data : r_fn;
        n_sum     = r_sum;
        n_count   = r_count;
        n_has_ext = r_has_ext;
        n_valid   = 1'b0;
        n_ext     = r_ext;
        n_res     = r_res;
        n_status  = r_status;
        n_empty   = r_empty;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_neg     = r_neg;
        unique case (i_cmd.op)
            DP_NONE: begin
            end
            DP_CLEAR: begin
                n_sum     = '0;
                n_count   = '0;
                n_has_ext = 1'b0;
                n_valid   = 1'b1;
                n_status  = ST_OK;
                n_res     = '0;
                n_empty   = 1'b0;
            end
            DP_VALUE: begin
                n_sum     = r_sum + w_value;
                n_count   = r_count + 1'b1;
                n_has_ext = 1'b1;
                if (w_repl) begin
                    n_ext = w_value;
                end
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_res    = '0;
                n_empty  = 1'b0;
            end
            DP_ROW: begin
                n_valid = 1'b1;
                n_res   = '0;
                n_empty = 1'b0;
                if (r_fn == FN_COUNT) begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_OK;
                end else begin
                    n_status = ST_ROW_ERR;
                end
            end
            DP_FINAL: begin
                n_valid  = 1'b1;
                n_status = ST_FINAL;
                n_res    = '0;
                n_empty  = 1'b0;
                // average only lands here with a zero count
                if (r_fn == FN_COUNT) begin
                    n_res = {{(VAL_W-CNT_W){1'b0}}, r_count};
                end else if (r_fn == FN_SUM) begin
                    n_res = r_sum;
                end else if (r_fn == FN_MIN || r_fn == FN_MAX) begin
                    if (r_has_ext) begin
                        n_res = r_ext;
                    end else begin
                        n_empty = 1'b1;
                    end
                end
            end
            DP_DIV_LOAD: begin
                n_neg = r_sum[VAL_W-1];
                n_quo = r_sum[VAL_W-1] ? (~r_sum + 1'b1) : r_sum;
                n_rem = '0;
            end
            DP_DIV_STEP: begin
                // restoring division, one quotient bit per cycle
                if (!w_diff[CNT_W+1]) begin
                    n_rem = w_diff[CNT_W-1:0];
                    n_quo = {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[CNT_W-1:0];
                    n_quo = {r_quo[VAL_W-2:0], 1'b0};
                end
            end
            DP_DIV_DONE: begin
                n_valid  = 1'b1;
                n_status = ST_FINAL;
                n_empty  = 1'b0;
                n_res    = r_neg ? (~r_quo + 1'b1) : r_quo;
            end
        endcase
    end

    assign o_stat.fn_avg     = (r_fn == FN_AVG);
    assign o_stat.count_zero = (r_count == '0);
    assign o_result_valid    = r_valid;
    assign o_status          = r_status;
    assign o_result_high     = r_res[VAL_W-1:HALF_W];
    assign o_result_low      = r_res[HALF_W-1:0];
    assign o_result_empty    = r_empty;

    a_nonfinal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_FINAL) |-> (r_res == '0 && !r_empty))
        else $error("non-final result carries data");

    a_empty_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_empty) |-> (r_status == ST_FINAL && r_res == '0))
        else $error("empty flag on a result that is not an empty extremum");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_CLEAR) |=> (r_sum == '0 && r_count == '0 && !r_has_ext))
        else $error("clear left accumulator state");

endmodule

`default_nettype wire

// ===== sv/numeric_aggregate_accumulator.sv =====
// Top level of the numeric aggregate accumulator (count, sum, average,
// minimum, maximum over signed 128-bit values). Depends on naa_pkg,
// naa_ctrl and naa_dp.
//
//   channel   | handshake              | payload
//   ----------+------------------------+-------------------------------------
//   request   | start, busy            | i_command, i_value_high, i_value_low
//   result    | o_result_valid strobe  | o_status, o_result_high/low, o_result_empty
//   config    | i_cfg_we               | i_cfg_data (function select)
//
// Clear, value, row and most finalize requests are handled straight from idle;
// the result strobe follows in the next cycle and a new request may be taken then.
// Finalize of average with a nonzero count loads the divider, runs the
// one-bit-per-cycle restoring divider, then restores the sign; busy is high
// while dividing and restoring the sign. Reset is synchronous on i_rst_n and
// clears the sum, count, extremum flag and function select. Results cannot be stalled.
`default_nettype none

module numeric_aggregate_accumulator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [naa_pkg::CMD_W-1:0]           i_command,
    input  wire logic signed [naa_pkg::HALF_W-1:0]   i_value_high,
    input  wire logic [naa_pkg::HALF_W-1:0]          i_value_low,
    input  wire logic                                i_cfg_we,
    input  wire logic [naa_pkg::FN_W-1:0]            i_cfg_data,
    output logic                                     o_result_valid,
    output logic [naa_pkg::STATUS_W-1:0]             o_status,
    output logic signed [naa_pkg::HALF_W-1:0]        o_result_high,
    output logic [naa_pkg::HALF_W-1:0]               o_result_low,
    output logic                                     o_result_empty
);
    import naa_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    naa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    naa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_value_high   (i_value_high),
        .i_value_low    (i_value_low),
        .o_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_result_high  (o_result_high),
        .o_result_low   (o_result_low),
        .o_result_empty (o_result_empty)
    );

endmodule

`default_nettype wire
